// ===== rtl/core/p15sf_pkg.sv =====
// ----------------------------------------------------------------------------
// p15sf_pkg - shared types and tables of the wedge shape function evaluator
// Factor codes, term table of the fifteen nodes and output constants.
// ----------------------------------------------------------------------------
package p15sf_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int COORD_W       = 16;
	localparam int OUT_W         = 20;
	localparam int NODE_COUNT    = 15;
	localparam int NODE_W        = 4;
	localparam int QTY_COUNT     = 4;
	localparam int TERM_COUNT    = 2;
	localparam int LANE_COUNT    = QTY_COUNT * TERM_COUNT;
	localparam int FAC_COUNT     = 13;
	localparam int IN_TDATA_W    = 48;
	localparam int OUT_TDATA_W   = 88;

	localparam logic signed [OUT_W-1:0] SAT_MAX = 20'sd524287;
	localparam logic signed [OUT_W-1:0] SAT_MIN = -20'sd524288;
	localparam logic [NODE_W-1:0] NODE_LAST = 4'(NODE_COUNT - 1);

	typedef enum logic [3:0] {
		F_X, F_Y, F_Z, F_O, F_L, F_M, F_P, F_A, F_B, F_C1, F_C2, F_D1, F_D2
	} fac_t;

	typedef struct packed {
		logic signed [3:0] k;
		fac_t              a;
		fac_t              b;
		fac_t              c;
	} term_t;

	function automatic term_t mk(input int k, input fac_t a, input fac_t b, input fac_t c);
		term_t r;
		r.k = 4'(k);
		r.a = a;
		r.b = b;
		r.c = c;
		return r;
	endfunction

	localparam term_t TZ = '{k: 4'sd0, a: F_O, b: F_O, c: F_O};

	// Each value is the sum of k*fa*fb*fc over the denominator 2*one^2.
	// Quantity 0 is the value, then d/dcsi, d/deta, d/dzeta.
	function automatic void node_terms(input logic [1:0] q, input logic [NODE_W-1:0] n,
			output term_t t0, output term_t t1);
		t0 = TZ;
		t1 = TZ;
		case (q)
			2'd0: begin
				case (n)
					4'd0:  t0 = mk(-1, F_L, F_M, F_A);
					4'd1:  t0 = mk( 1, F_X, F_M, F_C1);
					4'd2:  t0 = mk( 1, F_Y, F_M, F_C2);
					4'd3:  t0 = mk(-1, F_L, F_P, F_B);
					4'd4:  t0 = mk( 1, F_X, F_P, F_D1);
					4'd5:  t0 = mk( 1, F_Y, F_P, F_D2);
					4'd6:  t0 = mk( 4, F_X, F_L, F_M);
					4'd7:  t0 = mk( 4, F_Y, F_L, F_M);
					4'd8:  t0 = mk( 2, F_L, F_M, F_P);
					4'd9:  t0 = mk(-4, F_X, F_Y, F_M);
					4'd10: t0 = mk(-2, F_X, F_M, F_P);
					4'd11: t0 = mk(-2, F_Y, F_M, F_P);
					4'd12: t0 = mk(-4, F_X, F_L, F_P);
					4'd13: t0 = mk(-4, F_Y, F_L, F_P);
					4'd14: t0 = mk( 4, F_X, F_Y, F_P);
					default: t0 = TZ;
				endcase
			end
			2'd1: begin
				case (n)
					4'd0:  begin t0 = mk(-1, F_M, F_A, F_O);  t1 = mk(-2, F_L, F_M, F_O); end
					4'd1:  begin t0 = mk( 1, F_M, F_C1, F_O); t1 = mk(-2, F_X, F_M, F_O); end
					4'd3:  begin t0 = mk( 2, F_L, F_P, F_O);  t1 = mk(-1, F_P, F_B, F_O); end
					4'd4:  begin t0 = mk( 1, F_P, F_D1, F_O); t1 = mk( 2, F_X, F_P, F_O); end
					4'd6:  begin t0 = mk( 4, F_L, F_M, F_O);  t1 = mk( 4, F_X, F_M, F_O); end
					4'd7:  t0 = mk( 4, F_Y, F_M, F_O);
					4'd8:  t0 = mk( 2, F_M, F_P, F_O);
					4'd9:  t0 = mk(-4, F_Y, F_M, F_O);
					4'd10: t0 = mk(-2, F_M, F_P, F_O);
					4'd12: begin t0 = mk(-4, F_L, F_P, F_O);  t1 = mk(-4, F_X, F_P, F_O); end
					4'd13: t0 = mk(-4, F_Y, F_P, F_O);
					4'd14: t0 = mk( 4, F_Y, F_P, F_O);
					default: t0 = TZ;
				endcase
			end
			2'd2: begin
				case (n)
					4'd0:  begin t0 = mk(-1, F_M, F_A, F_O);  t1 = mk(-2, F_L, F_M, F_O); end
					4'd2:  begin t0 = mk( 1, F_M, F_C2, F_O); t1 = mk(-2, F_Y, F_M, F_O); end
					4'd3:  begin t0 = mk( 2, F_L, F_P, F_O);  t1 = mk(-1, F_P, F_B, F_O); end
					4'd5:  begin t0 = mk( 1, F_P, F_D2, F_O); t1 = mk( 2, F_Y, F_P, F_O); end
					4'd6:  t0 = mk( 4, F_X, F_M, F_O);
					4'd7:  begin t0 = mk( 4, F_L, F_M, F_O);  t1 = mk( 4, F_Y, F_M, F_O); end
					4'd8:  t0 = mk( 2, F_M, F_P, F_O);
					4'd9:  t0 = mk(-4, F_X, F_M, F_O);
					4'd11: t0 = mk(-2, F_M, F_P, F_O);
					4'd12: t0 = mk(-4, F_X, F_P, F_O);
					4'd13: begin t0 = mk(-4, F_L, F_P, F_O);  t1 = mk(-4, F_Y, F_P, F_O); end
					4'd14: t0 = mk( 4, F_X, F_P, F_O);
					default: t0 = TZ;
				endcase
			end
			default: begin
				case (n)
					4'd0:  begin t0 = mk(-1, F_L, F_A, F_O);  t1 = mk(-1, F_L, F_M, F_O); end
					4'd1:  begin t0 = mk( 1, F_X, F_C1, F_O); t1 = mk( 1, F_X, F_M, F_O); end
					4'd2:  begin t0 = mk( 1, F_Y, F_C2, F_O); t1 = mk( 1, F_Y, F_M, F_O); end
					4'd3:  begin t0 = mk(-1, F_L, F_B, F_O);  t1 = mk(-1, F_L, F_P, F_O); end
					4'd4:  begin t0 = mk( 1, F_X, F_D1, F_O); t1 = mk( 1, F_X, F_P, F_O); end
					4'd5:  begin t0 = mk( 1, F_Y, F_D2, F_O); t1 = mk( 1, F_Y, F_P, F_O); end
					4'd6:  t0 = mk( 4, F_X, F_L, F_O);
					4'd7:  t0 = mk( 4, F_Y, F_L, F_O);
					4'd8:  t0 = mk( 4, F_L, F_Z, F_O);
					4'd9:  t0 = mk(-4, F_X, F_Y, F_O);
					4'd10: t0 = mk(-4, F_X, F_Z, F_O);
					4'd11: t0 = mk(-4, F_Y, F_Z, F_O);
					4'd12: t0 = mk(-4, F_X, F_L, F_O);
					4'd13: t0 = mk(-4, F_Y, F_L, F_O);
					4'd14: t0 = mk( 4, F_X, F_Y, F_O);
					default: t0 = TZ;
				endcase
			end
		endcase
	endfunction

endpackage

// ===== rtl/core/prism15_shape_function_eval.sv =====
// ----------------------------------------------------------------------------
// prism15_shape_function_eval - 15-node wedge shape functions and derivatives
// Takes one natural coordinate point per item and emits fifteen node items.
// ----------------------------------------------------------------------------
// The factor register, then four pipeline stages, lie between the accepting
// of a point and its first node item valid on m_axis.
// Throughput: one node item per cycle unless m_axis_tready stalls the pipe;
// the sequencer likewise issues one node per cycle, and the next point
// enters as node 14 issues. Reset clears the sequencer and valid bits only.
module prism15_shape_function_eval
	import p15sf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // csi, eta, zeta
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // node_index, shape_value,
	                                              // deriv_first, deriv_second,
	                                              // deriv_axial, zero pad
	output logic                   m_axis_tlast   // last
);

	localparam int FW = (FRAC_BITS + 4 > 19) ? FRAC_BITS + 4 : 19;
	localparam int KW = FW + 3;
	localparam int PW = KW + FW;
	localparam int TW = PW + FW;
	localparam int AW = TW + 2;
	localparam int SH = 2 * FRAC_BITS + 1;

	logic signed [FW-1:0] fac_q [FAC_COUNT];
	logic signed [FW-1:0] fac_n [FAC_COUNT];
	logic [NODE_W-1:0]    node_q;
	logic                 busy_q;
	logic                 ce;
	logic                 accept;

	logic signed [KW-1:0] kf_s1 [LANE_COUNT];
	logic signed [FW-1:0] fb_s1 [LANE_COUNT];
	logic signed [FW-1:0] fc_s1 [LANE_COUNT];
	logic [NODE_W-1:0]    node_s1;
	logic                 v_s1;

	logic signed [PW-1:0] p_s2  [LANE_COUNT];
	logic signed [FW-1:0] fc_s2 [LANE_COUNT];
	logic [NODE_W-1:0]    node_s2;
	logic                 v_s2;

	logic signed [TW-1:0] t_s3 [LANE_COUNT];
	logic [NODE_W-1:0]    node_s3;
	logic                 v_s3;

	logic signed [OUT_W-1:0] res_n [QTY_COUNT];
	logic signed [OUT_W-1:0] res_s4 [QTY_COUNT];
	logic [NODE_W-1:0]       node_s4;
	logic                    v_s4;

	term_t lane_term [LANE_COUNT];

	// hold the whole pipe while the output item is not taken
	assign ce            = !v_s4 || m_axis_tready;
	assign s_axis_tready = ce && (!busy_q || node_q == NODE_LAST);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		logic signed [FW-1:0] x, y, z, one, s;
		x   = FW'(signed'(s_axis_tdata[15:0]));
		y   = FW'(signed'(s_axis_tdata[31:16]));
		z   = FW'(signed'(s_axis_tdata[47:32]));
		one = FW'(1) <<< FRAC_BITS;
		s   = x + y;
		fac_n[F_X]  = x;
		fac_n[F_Y]  = y;
		fac_n[F_Z]  = z;
		fac_n[F_O]  = one;
		fac_n[F_L]  = s - one;
		fac_n[F_M]  = z - one;
		fac_n[F_P]  = z + one;
		fac_n[F_A]  = (s <<< 1) + z;
		fac_n[F_B]  = z - (s <<< 1);
		fac_n[F_C1] = (one <<< 1) - (x <<< 1) + z;
		fac_n[F_C2] = (one <<< 1) - (y <<< 1) + z;
		fac_n[F_D1] = (x <<< 1) + z - (one <<< 1);
		fac_n[F_D2] = (y <<< 1) + z - (one <<< 1);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < FAC_COUNT; i++) fac_q[i] <= fac_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			node_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			node_q <= '0;
		end else if (ce && busy_q) begin
			if (node_q == NODE_LAST) begin
				busy_q <= 1'b0;
			end
			node_q <= node_q + NODE_W'(1);
		end
	end

	always_comb begin
		for (int q = 0; q < QTY_COUNT; q++) begin
			node_terms(2'(q), node_q, lane_term[2*q], lane_term[2*q+1]);
		end
	end

	// stage 1: pick operands and scale by the coefficient
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < LANE_COUNT; l++) begin
				kf_s1[l] <= KW'(lane_term[l].k) * KW'(fac_q[lane_term[l].a]);
				fb_s1[l] <= fac_q[lane_term[l].b];
				fc_s1[l] <= fac_q[lane_term[l].c];
			end
			node_s1 <= node_q;
		end
	end

	// stage 2 and 3: two multiplies
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < LANE_COUNT; l++) begin
				p_s2[l]  <= PW'(kf_s1[l]) * PW'(fb_s1[l]);
				fc_s2[l] <= fc_s1[l];
				t_s3[l]  <= TW'(p_s2[l]) * TW'(fc_s2[l]);
			end
			node_s2 <= node_s1;
			node_s3 <= node_s2;
		end
	end

	// stage 4: add term pair, round half up, saturate
	always_comb begin
		logic signed [AW-1:0] acc, rnd;
		for (int q = 0; q < QTY_COUNT; q++) begin
			acc = AW'(t_s3[2*q]) + AW'(t_s3[2*q+1]) + (AW'(1) <<< (SH - 1));
			rnd = acc >>> SH;
			if (rnd > AW'(SAT_MAX)) begin
				res_n[q] = SAT_MAX;
			end else if (rnd < AW'(SAT_MIN)) begin
				res_n[q] = SAT_MIN;
			end else begin
				res_n[q] = rnd[OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int q = 0; q < QTY_COUNT; q++) res_s4[q] <= res_n[q];
			node_s4 <= node_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s1 <= busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tlast  = (node_s4 == NODE_LAST);
	assign m_axis_tdata  = {4'b0, res_s4[3], res_s4[2], res_s4[1], res_s4[0], node_s4};

endmodule
